@@ rtl/recent_list_with_use_counts_assert.svh @@
// ----------------------------------------------------------------------------
// recent list assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RECENT_LIST_WITH_USE_COUNTS_ASSERT_SVH
`define RECENT_LIST_WITH_USE_COUNTS_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define RLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define RLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RLC_ASSERT(lbl, clk, rstn, prop)
`define RLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RLC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/rlc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlc_pkg
// shared types and constants of the recent list with use counters
// ----------------------------------------------------------------------------
package rlc_pkg;

    localparam int RECENT_DEPTH_DEF  = 16;
    localparam int COUNT_ENTRIES_DEF = 64;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;
    localparam int POS_W   = 4;
    localparam int USED_W  = 5;
    localparam int CENT_W  = KEY_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic FUNC_PLAY  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] game_hash;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] play_count;
        logic               was_recent;
        logic [POS_W-1:0]   old_position;
        logic               evicted_valid;
        logic [KEY_W-1:0]   evicted_hash;
        logic               table_full;
        logic [USED_W-1:0]  recent_used;
    } t_out;

endpackage

@@ rtl/rlc_ram.sv @@
// ----------------------------------------------------------------------------
// rlc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rlc_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/recent_list_with_use_counts.sv @@
// ----------------------------------------------------------------------------
// recent_list_with_use_counts
// move-to-front recent list with saturating per-key use counters
// ----------------------------------------------------------------------------
// A play item scans the list ram for its key (the whole list on a miss),
// moves the entries in front of the position the key moves from (the list
// tail for a new key once the list is full) back by one, writes the key to
// the front and then scans the counter ram (all entries in use on a miss).
// A query item only scans the counter ram. One shared 32-bit key
// comparator walks the list ram and then the counter ram one entry per
// cycle, and the single write port of the list ram moves one entry per
// cycle during the move to front. Input ready is high only between items; a
// finished result waits in the output register while the next item is
// already being worked on. No clearing pass is needed after reset.
`include "recent_list_with_use_counts_assert.svh"

module recent_list_with_use_counts #(
    parameter int RECENT_DEPTH  = rlc_pkg::RECENT_DEPTH_DEF,
    parameter int COUNT_ENTRIES = rlc_pkg::COUNT_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rlc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rlc_pkg::t_out o_out_data
);

    import rlc_pkg::*;

    localparam int RA = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int RL = $clog2(RECENT_DEPTH + 1);
    localparam int CA = (COUNT_ENTRIES > 1) ? $clog2(COUNT_ENTRIES) : 1;
    localparam int CL = $clog2(COUNT_ENTRIES + 1);

    localparam logic [RL-1:0] RLEN_MAX  = RL'(RECENT_DEPTH);
    localparam logic [CL-1:0] CUSED_MAX = CL'(COUNT_ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RSCAN = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // control
    logic [2:0]    r_state, n_state;
    logic [RL-1:0] r_rlen, n_rlen;
    logic [CL-1:0] r_cused, n_cused;
    logic          r_rpend, n_rpend;
    logic          r_cpend, n_cpend;
    logic          r_ovalid, n_ovalid;

    // payload
    logic             r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [RL-1:0]    r_ridx, n_ridx;
    logic [RL-1:0]    r_rpidx, n_rpidx;
    logic [CL-1:0]    r_cidx, n_cidx;
    logic [CL-1:0]    r_cpidx, n_cpidx;
    t_out             r_res, n_res;
    t_out             r_out, n_out;

    // list ram
    logic             rr_wr_en, rr_rd_en;
    logic [RA-1:0]    rr_wr_addr, rr_rd_addr;
    logic [KEY_W-1:0] rr_wr_data, rr_rd_data;

    // counter ram, key in the upper bits
    logic              cr_wr_en, cr_rd_en;
    logic [CA-1:0]     cr_wr_addr, cr_rd_addr;
    logic [CENT_W-1:0] cr_wr_data, cr_rd_data;

    logic [KEY_W-1:0]         cmp_key;
    logic                     key_eq;
    logic [COUNT_W-1:0]       c_val, c_inc;
    logic [RA+POS_W-1:0]      pos_ext;
    logic [RL+USED_W-1:0]     used_ext;

    rlc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RECENT_DEPTH)
    ) u_list_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rr_wr_en),
        .i_wr_addr (rr_wr_addr),
        .i_wr_data (rr_wr_data),
        .i_rd_en   (rr_rd_en),
        .i_rd_addr (rr_rd_addr),
        .o_rd_data (rr_rd_data)
    );

    rlc_ram #(
        .WIDTH (CENT_W),
        .DEPTH (COUNT_ENTRIES)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cr_wr_en),
        .i_wr_addr (cr_wr_addr),
        .i_wr_data (cr_wr_data),
        .i_rd_en   (cr_rd_en),
        .i_rd_addr (cr_rd_addr),
        .o_rd_data (cr_rd_data)
    );

    // one comparator serves both scans
    assign cmp_key = (r_state == S_RSCAN) ? rr_rd_data : cr_rd_data[CENT_W-1:COUNT_W];
    assign key_eq  = (cmp_key == r_key);

    assign c_val    = cr_rd_data[COUNT_W-1:0];
    assign c_inc    = (c_val == COUNT_MAX) ? c_val : c_val + 1'b1;
    assign pos_ext  = {{POS_W{1'b0}}, r_rpidx[RA-1:0]};
    assign used_ext = {{USED_W{1'b0}}, r_rlen};

    always_comb begin
        n_state  = r_state;
        n_rlen   = r_rlen;
        n_cused  = r_cused;
        n_rpend  = r_rpend;
        n_cpend  = r_cpend;
        n_ovalid = r_ovalid;
        n_func   = r_func;
        n_key    = r_key;
        n_ridx   = r_ridx;
        n_rpidx  = r_rpidx;
        n_cidx   = r_cidx;
        n_cpidx  = r_cpidx;
        n_res    = r_res;
        n_out    = r_out;

        rr_wr_en   = 1'b0;
        rr_wr_addr = '0;
        rr_wr_data = '0;
        rr_rd_en   = 1'b0;
        rr_rd_addr = '0;
        cr_wr_en   = 1'b0;
        cr_wr_addr = '0;
        cr_wr_data = '0;
        cr_rd_en   = 1'b0;
        cr_rd_addr = '0;

        if (i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_key   = i_in_data.game_hash;
                    n_ridx  = '0;
                    n_rpend = 1'b0;
                    n_cidx  = '0;
                    n_cpend = 1'b0;
                    n_res   = '0;
                    n_state = (i_in_data.func == FUNC_QUERY) ? S_CSCAN : S_RSCAN;
                end
            end

            S_RSCAN: begin
                if (r_rpend && key_eq) begin
                    n_res.was_recent   = 1'b1;
                    n_res.old_position = pos_ext[POS_W-1:0];
                    n_ridx             = r_rpidx;
                    n_rpend            = 1'b0;
                    n_state            = S_SHIFT;
                end else if (r_ridx == r_rlen) begin
                    // miss: the read register holds the tail entry when full
                    if (r_rlen == RLEN_MAX) begin
                        n_res.evicted_valid = 1'b1;
                        n_res.evicted_hash  = rr_rd_data;
                        n_ridx              = RLEN_MAX - 1'b1;
                    end else begin
                        n_ridx = r_rlen;
                        n_rlen = r_rlen + 1'b1;
                    end
                    n_rpend = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    rr_rd_en   = 1'b1;
                    rr_rd_addr = r_ridx[RA-1:0];
                    n_rpidx    = r_ridx;
                    n_ridx     = r_ridx + 1'b1;
                    n_rpend    = 1'b1;
                end
            end

            S_SHIFT: begin
                // r_ridx is the next slot to fill from the one above it
                if (r_rpend) begin
                    rr_wr_en   = 1'b1;
                    rr_wr_addr = r_rpidx[RA-1:0];
                    rr_wr_data = rr_rd_data;
                end
                if (r_ridx != '0) begin
                    rr_rd_en   = 1'b1;
                    rr_rd_addr = RA'(r_ridx - 1'b1);
                    n_rpidx    = r_ridx;
                    n_ridx     = r_ridx - 1'b1;
                    n_rpend    = 1'b1;
                end else begin
                    n_rpend = 1'b0;
                    if (!r_rpend) begin
                        rr_wr_en   = 1'b1;
                        rr_wr_addr = '0;
                        rr_wr_data = r_key;
                        n_state    = S_CSCAN;
                    end
                end
            end

            S_CSCAN: begin
                if (r_cpend && key_eq) begin
                    if (r_func == FUNC_PLAY) begin
                        cr_wr_en         = 1'b1;
                        cr_wr_addr       = r_cpidx[CA-1:0];
                        cr_wr_data       = {r_key, c_inc};
                        n_res.play_count = c_inc;
                    end else begin
                        n_res.play_count = c_val;
                    end
                    n_cpend = 1'b0;
                    n_state = S_DONE;
                end else if (r_cidx == r_cused) begin
                    if (r_func == FUNC_QUERY) begin
                        n_res.play_count = '0;
                    end else if (r_cused != CUSED_MAX) begin
                        cr_wr_en         = 1'b1;
                        cr_wr_addr       = r_cused[CA-1:0];
                        cr_wr_data       = {r_key, COUNT_W'(1)};
                        n_cused          = r_cused + 1'b1;
                        n_res.play_count = COUNT_W'(1);
                    end else begin
                        n_res.table_full = 1'b1;
                        n_res.play_count = '0;
                    end
                    n_cpend = 1'b0;
                    n_state = S_DONE;
                end else begin
                    cr_rd_en   = 1'b1;
                    cr_rd_addr = r_cidx[CA-1:0];
                    n_cpidx    = r_cidx;
                    n_cidx     = r_cidx + 1'b1;
                    n_cpend    = 1'b1;
                end
            end

            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.recent_used = used_ext[USED_W-1:0];
                    n_ovalid          = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rlen   <= '0;
            r_cused  <= '0;
            r_rpend  <= 1'b0;
            r_cpend  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rlen   <= n_rlen;
            r_cused  <= n_cused;
            r_rpend  <= n_rpend;
            r_cpend  <= n_cpend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_key   <= n_key;
        r_ridx  <= n_ridx;
        r_rpidx <= n_rpidx;
        r_cidx  <= n_cidx;
        r_cpidx <= n_cpidx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `RLC_ASSERT(a_rlen_range, i_clk, i_rst_n, r_rlen <= RLEN_MAX)
    `RLC_ASSERT(a_cused_range, i_clk, i_rst_n, r_cused <= CUSED_MAX)
    `RLC_ASSERT_NXT(a_rlen_only_in_scan, i_clk, i_rst_n,
        r_state != S_RSCAN, $stable(r_rlen))
    `RLC_ASSERT_IMP(a_full_only_when_full, i_clk, i_rst_n,
        r_state == S_DONE && r_res.table_full, r_cused == CUSED_MAX)
    `RLC_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n,
        r_state == S_DONE, !(r_res.was_recent && r_res.evicted_valid))

endmodule

@@ tb/tb_recent_list_with_use_counts.sv @@
// ----------------------------------------------------------------------------
// tb_recent_list_with_use_counts
// Self-checking bench for the move-to-front recent list with use counters.
// A scoreboard class keeps its own copy of the recent list and the counter
// table. It predicts one result per accepted item and checks every result
// field by field. The directed items cover queries on an empty block, a
// counter counting up, list eviction, and moves from the tail and the
// front. The random items draw keys from a hot set, from a wider pool
// and from the full 32-bit space. This fills the counter table and keeps
// hitting the list. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_recent_list_with_use_counts;
    timeunit 1ns;
    timeprecision 1ps;

    import rlc_pkg::*;

    localparam int LIST_DEPTH   = RECENT_DEPTH_DEF;
    localparam int CTR_ENTRIES  = COUNT_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1470;
    localparam int POOL_KEYS    = 96;
    localparam int HOT_KEYS     = 20;
    localparam int DRAIN_CYCLES = 150;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_STALLS} t_rx_mode;

    // predicts the list and counter state and checks results in order
    class use_count_scoreboard;
        logic [KEY_W-1:0]   list_keys[LIST_DEPTH];
        int                 list_len;
        logic [KEY_W-1:0]   ctr_keys[CTR_ENTRIES];
        logic [COUNT_W-1:0] ctr_vals[CTR_ENTRIES];
        int                 ctr_used;
        t_out               expected_q[$];
        int unsigned        errors, checked;
        int unsigned        n_play, n_query, n_hit, n_tail_hit, n_evict, n_full, n_sat;

        function new();
            list_len = 0;
            ctr_used = 0;
            errors   = 0;
            checked  = 0;
            n_play = 0; n_query = 0; n_hit = 0; n_tail_hit = 0;
            n_evict = 0; n_full = 0; n_sat = 0;
        endfunction

        function int counter_slot(logic [KEY_W-1:0] key);
            int k;
            for (k = 0; k < ctr_used; k++)
                if (ctr_keys[k] == key)
                    return k;
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(t_in item);
            t_out r;
            int   pos, slot, k;
            bit   hit;
            r    = '0;
            hit  = 0;
            pos  = 0;
            slot = counter_slot(item.game_hash);
            if (item.func == FUNC_PLAY) begin
                n_play++;
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_keys[k] == item.game_hash) begin
                        hit = 1;
                        pos = k;
                    end
                end
                if (!hit) begin
                    if (list_len == LIST_DEPTH) begin
                        r.evicted_valid = 1'b1;
                        r.evicted_hash  = list_keys[LIST_DEPTH-1];
                        pos = LIST_DEPTH - 1;
                        n_evict++;
                    end else begin
                        pos = list_len;
                        list_len++;
                    end
                end
                for (k = pos; k > 0; k--)
                    list_keys[k] = list_keys[k-1];
                list_keys[0] = item.game_hash;
                if (hit) begin
                    r.was_recent   = 1'b1;
                    r.old_position = POS_W'(pos);
                    n_hit++;
                    if (pos == LIST_DEPTH - 1)
                        n_tail_hit++;
                end
                if (slot >= 0) begin
                    if (ctr_vals[slot] != COUNT_MAX)
                        ctr_vals[slot]++;
                    r.play_count = ctr_vals[slot];
                end else if (ctr_used < CTR_ENTRIES) begin
                    ctr_keys[ctr_used] = item.game_hash;
                    ctr_vals[ctr_used] = COUNT_W'(1);
                    ctr_used++;
                    r.play_count = COUNT_W'(1);
                end else begin
                    r.table_full = 1'b1;
                    n_full++;
                end
            end else begin
                n_query++;
                if (slot >= 0)
                    r.play_count = ctr_vals[slot];
            end
            if (r.play_count == COUNT_MAX)
                n_sat++;
            r.recent_used = USED_W'(list_len);
            expected_q = {expected_q, r};
        endfunction

        function bit field_ok(string fld, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
                return 0;
            end
            return 1;
        endfunction

        function void check_result(t_out got);
            t_out want;
            bit   ok;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            ok = 1;
            ok = field_ok("play_count", KEY_W'(want.play_count),
                          KEY_W'(got.play_count)) & ok;
            ok = field_ok("was_recent", KEY_W'(want.was_recent),
                          KEY_W'(got.was_recent)) & ok;
            ok = field_ok("old_position", KEY_W'(want.old_position),
                          KEY_W'(got.old_position)) & ok;
            ok = field_ok("evicted_valid", KEY_W'(want.evicted_valid),
                          KEY_W'(got.evicted_valid)) & ok;
            ok = field_ok("evicted_hash", want.evicted_hash, got.evicted_hash) & ok;
            ok = field_ok("table_full", KEY_W'(want.table_full),
                          KEY_W'(got.table_full)) & ok;
            ok = field_ok("recent_used", KEY_W'(want.recent_used),
                          KEY_W'(got.recent_used)) & ok;
            if (!ok)
                errors++;
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    use_count_scoreboard sb = new();
    int unsigned      burst_left  = 0;
    logic [KEY_W-1:0] key_pool[POOL_KEYS];

    recent_list_with_use_counts #(
        .RECENT_DEPTH  (LIST_DEPTH),
        .COUNT_ENTRIES (CTR_ENTRIES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready)
                sb.note_item(in_data);
            if (o_out_valid && out_ready)
                sb.check_result(o_out_data);
        end
    end

    // receiver: runs each randomly chosen stall pattern for a random span, then picks another
    initial begin
        t_rx_mode    mode;
        int unsigned span, stall_left;
        stall_left = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(3));
            span = $urandom_range(600, 40);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(3) != 0);
                    RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            out_ready <= 1'b0;
                        end else begin
                            out_ready <= 1'b1;
                            if ($urandom_range(15) == 0)
                                stall_left = $urandom_range(40, 1);
                        end
                    end
                endcase
            end
        end
    end

    // sends one item, opening a random gap at the end of each burst
    task automatic issue(logic func, logic [KEY_W-1:0] key);
        t_in         it;
        int unsigned gap;
        it.func      = func;
        it.game_hash = key;
        if (burst_left == 0) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(200, 50)
                                                  : $urandom_range(24, 1);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!o_in_ready);
    endtask

    initial begin
        int unsigned      k, sel;
        logic             func;
        logic [KEY_W-1:0] key;

        for (k = 0; k < POOL_KEYS; k++)
            key_pool[k] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty block: both extreme keys are absent
        issue(FUNC_QUERY, '0);
        issue(FUNC_QUERY, '1);

        // one key counts up, repeated plays hit the front of the list
        repeat (3) issue(FUNC_PLAY, '1);
        issue(FUNC_QUERY, '1);

        // second key, then the first key moves up from position one
        issue(FUNC_PLAY, '0);
        issue(FUNC_PLAY, '1);

        // overfill the list: the two oldest keys drop off the tail
        for (k = 0; k < LIST_DEPTH; k++)
            issue(FUNC_PLAY, 32'h1000_0000 + k);
        // first of those is now at the tail, then at the front
        issue(FUNC_PLAY, 32'h1000_0000);
        issue(FUNC_PLAY, 32'h1000_0000);
        // evicted key keeps its counter, unknown key reads zero
        issue(FUNC_QUERY, '0);
        issue(FUNC_QUERY, 32'h5555_5555);
        issue(FUNC_PLAY, '1);

        // random part: hot keys hit the list, the wider pool fills the table
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            func = ($urandom_range(99) < 30) ? FUNC_QUERY : FUNC_PLAY;
            sel  = $urandom_range(99);
            if (sel < 55)
                key = key_pool[$urandom_range(HOT_KEYS - 1)];
            else if (sel < 90)
                key = key_pool[$urandom_range(POOL_KEYS - 1)];
            else
                key = $urandom;
            issue(func, key);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d plays, %0d queries, %0d list hits (%0d at the tail)",
                 sb.checked, sb.n_play, sb.n_query, sb.n_hit, sb.n_tail_hit);
        $display("%0d evictions, %0d plays refused by a full counter table, %0d saturated counts",
                 sb.n_evict, sb.n_full, sb.n_sat);
        if (sb.errors == 0)
            $display("PASS recent_list_with_use_counts");
        else
            $display("FAIL recent_list_with_use_counts");
        $finish;
    end

    // about 1500 items finish well inside this limit
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("FAIL recent_list_with_use_counts");
        $finish;
    end

endmodule
